// ===== rtl/core/rumble_pulse_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RUMBLE_PULSE_SEQUENCER_DEFINES_SVH
`define RUMBLE_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// Next-cycle implication, disabled in reset
`define RPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);

`endif

// ===== rtl/core/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer package
// Request and result types, request and motor command codes, damage table.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_SINGLE = 2'd2;
  localparam logic [1:0] REQ_DAMAGE = 2'd3;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_RUMBLE = 2'd1;
  localparam logic [1:0] CMD_SOFT   = 2'd2;
  localparam logic [1:0] CMD_HARD   = 2'd3;

  localparam logic [15:0] DMG_HEAVY  = 16'd100;
  localparam logic [15:0] DMG_HIGH   = 16'd50;
  localparam logic [15:0] DMG_MID    = 16'd25;
  localparam logic [15:0] DMG_LOW    = 16'd10;

  localparam logic [5:0]  LEN_HEAVY  = 6'd60;
  localparam logic [5:0]  LEN_HIGH   = 6'd20;
  localparam logic [5:0]  LEN_MID    = 6'd12;
  localparam logic [5:0]  LEN_LOW    = 6'd9;
  localparam logic [5:0]  LEN_MIN    = 6'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] on_frames;
    logic [15:0] off_frames;
    logic [7:0]  pulse_count;
    logic        hard_stop;
    logic [15:0] single_frames;
    logic [15:0] damage_amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  motor_cmd;
    logic        motor_running;
    logic [15:0] ticks_left;
  } res_t;

  function automatic logic [5:0] damage_len(input logic [15:0] amount);
    logic [5:0] len;
    begin
      if (amount >= DMG_HEAVY) begin
        len = LEN_HEAVY;
      end else if (amount >= DMG_HIGH) begin
        len = LEN_HIGH;
      end else if (amount >= DMG_MID) begin
        len = LEN_MID;
      end else if (amount >= DMG_LOW) begin
        len = LEN_LOW;
      end else if (amount != 16'd0) begin
        len = LEN_MIN;
      end else begin
        len = 6'd0;
      end
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rps_in_reg.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer input register
// Holds one request until the sequencing stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rps_pkg::req_t in_req,
  input  wire logic          advance,
  output logic               held_valid,
  output rps_pkg::req_t      held_req
);
  import rps_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_req <= in_req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rps_engine.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer engine
// Pattern state and its single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_engine #(
  parameter int FRAME_WIDTH = 16,
  parameter int PULSE_WIDTH = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire rps_pkg::req_t req,
  output rps_pkg::res_t      res
);
  import rps_pkg::*;

  localparam int SW  = (FRAME_WIDTH > 16) ? FRAME_WIDTH : 16;
  localparam int PSW = (PULSE_WIDTH > 8) ? PULSE_WIDTH : 8;
  localparam logic [SW-1:0]  FRAME_MAX = SW'({FRAME_WIDTH{1'b1}});
  localparam logic [PSW-1:0] PULSE_MAX = PSW'({PULSE_WIDTH{1'b1}});

  logic [FRAME_WIDTH-1:0] countdown, countdown_next;
  logic [FRAME_WIDTH-1:0] on_length, on_length_next;
  logic [FRAME_WIDTH-1:0] off_length, off_length_next;
  logic [PULSE_WIDTH-1:0] pulses_remaining, pulses_remaining_next;
  logic                   motor_on, motor_on_next;
  logic                   stop_hard, stop_hard_next;

  logic [FRAME_WIDTH-1:0] on_sat, off_sat, single_sat, cd_dec;
  logic [PSW-1:0]         cnt_w;
  logic [PULSE_WIDTH-1:0] cnt_sat;
  logic [15:0]            single_raw;
  logic [SW-1:0]          cd_wide;
  logic [1:0]             cmd;

  function automatic logic [FRAME_WIDTH-1:0] sat_frame(input logic [15:0] v);
    logic [SW-1:0] w;
    begin
      w = SW'(v);
      if (w > FRAME_MAX) begin
        w = FRAME_MAX;
      end
      return w[FRAME_WIDTH-1:0];
    end
  endfunction

  assign single_raw = (req.req_type == REQ_SINGLE) ? req.single_frames
                                                   : 16'(damage_len(req.damage_amount));
  assign on_sat     = sat_frame(req.on_frames);
  assign off_sat    = sat_frame(req.off_frames);
  assign single_sat = sat_frame(single_raw);
  assign cnt_w      = PSW'(req.pulse_count);
  assign cnt_sat    = (cnt_w > PULSE_MAX) ? PULSE_MAX[PULSE_WIDTH-1:0]
                                          : cnt_w[PULSE_WIDTH-1:0];
  assign cd_dec     = countdown - FRAME_WIDTH'(1);

  always_comb begin
    countdown_next        = countdown;
    on_length_next        = on_length;
    off_length_next       = off_length;
    pulses_remaining_next = pulses_remaining;
    motor_on_next         = motor_on;
    stop_hard_next        = stop_hard;
    cmd                   = CMD_NONE;
    unique case (req.req_type) inside
      REQ_TICK: begin
        if (countdown != '0) begin
          countdown_next = cd_dec;
          if (cd_dec == '0) begin
            if (!motor_on) begin
              motor_on_next  = 1'b1;
              countdown_next = on_length;
              cmd            = CMD_RUMBLE;
            end else if (pulses_remaining <= PULSE_WIDTH'(1)) begin
              pulses_remaining_next = '0;
              motor_on_next         = 1'b0;
              cmd                   = stop_hard ? CMD_HARD : CMD_SOFT;
            end else begin
              pulses_remaining_next = pulses_remaining - PULSE_WIDTH'(1);
              if (off_length != '0) begin
                motor_on_next  = 1'b0;
                countdown_next = off_length;
                cmd            = CMD_SOFT;
              end else begin
                countdown_next = on_length;
              end
            end
          end
        end
      end
      REQ_START: begin
        if (on_sat != '0 && cnt_sat != '0) begin
          on_length_next        = on_sat;
          off_length_next       = off_sat;
          pulses_remaining_next = cnt_sat;
          countdown_next        = on_sat;
          motor_on_next         = 1'b1;
          stop_hard_next        = req.hard_stop;
          cmd                   = CMD_RUMBLE;
        end
      end
      REQ_SINGLE, REQ_DAMAGE: begin
        if (single_sat != '0) begin
          if (motor_on && pulses_remaining == PULSE_WIDTH'(1)) begin
            if (single_sat > countdown) begin
              countdown_next = single_sat;
            end
          end else begin
            on_length_next        = single_sat;
            off_length_next       = '0;
            pulses_remaining_next = PULSE_WIDTH'(1);
            countdown_next        = single_sat;
            motor_on_next         = 1'b1;
            stop_hard_next        = 1'b1;
            cmd                   = CMD_RUMBLE;
          end
        end
      end
    endcase
  end

  assign cd_wide           = SW'(countdown_next);
  assign res.motor_cmd     = cmd;
  assign res.motor_running = motor_on_next;
  assign res.ticks_left    = cd_wide[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown        <= '0;
      on_length        <= '0;
      off_length       <= '0;
      pulses_remaining <= '0;
      motor_on         <= 1'b0;
      stop_hard        <= 1'b0;
    end else if (advance) begin
      countdown        <= countdown_next;
      on_length        <= on_length_next;
      off_length       <= off_length_next;
      pulses_remaining <= pulses_remaining_next;
      motor_on         <= motor_on_next;
      stop_hard        <= stop_hard_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rps_out_reg.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          held_valid,
  input  wire rps_pkg::res_t res_in,
  output logic               advance,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rps_pkg::res_t      res_out
);
  import rps_pkg::*;

  assign advance = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rumble_pulse_sequencer.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer
// Vibration motor pulse patterns driven by ticks, starts, pulses and damage.
// ----------------------------------------------------------------------------
// Channel    Handshake               Payload
// request    req_valid / req_ready   req_type .. damage_amount
// result     res_valid / res_ready   motor_cmd, motor_running, ticks_left
//
// Path from request to result: input register, then the state update and
// result register. One request per cycle sustained while res_ready is high.
// Synchronous reset clears the pattern state and both valid flags.
// A stalled result holds the held request; requests stop only when both
// registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module rumble_pulse_sequencer #(
  parameter int FRAME_WIDTH = 16,
  parameter int PULSE_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] on_frames,
  input  wire logic [15:0] off_frames,
  input  wire logic [7:0]  pulse_count,
  input  wire logic        hard_stop,
  input  wire logic [15:0] single_frames,
  input  wire logic [15:0] damage_amount,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       motor_cmd,
  output logic             motor_running,
  output logic [15:0]      ticks_left
);
  import rps_pkg::*;

  req_t in_req, held_req;
  res_t res_next, res_q;
  logic held_valid;
  logic advance;

  assign in_req.req_type      = req_type;
  assign in_req.on_frames     = on_frames;
  assign in_req.off_frames    = off_frames;
  assign in_req.pulse_count   = pulse_count;
  assign in_req.hard_stop     = hard_stop;
  assign in_req.single_frames = single_frames;
  assign in_req.damage_amount = damage_amount;

  rps_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req_valid),
    .in_ready   (req_ready),
    .in_req     (in_req),
    .advance    (advance),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  rps_engine #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .PULSE_WIDTH (PULSE_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (held_req),
    .res     (res_next)
  );

  rps_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res_in     (res_next),
    .advance    (advance),
    .out_valid  (res_valid),
    .out_ready  (res_ready),
    .res_out    (res_q)
  );

  assign motor_cmd     = res_q.motor_cmd;
  assign motor_running = res_q.motor_running;
  assign ticks_left    = res_q.ticks_left;

endmodule

`default_nettype wire

// ===== rtl/core/rps_checker.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer port checker
// Port-level checks on results and request latency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rumble_pulse_sequencer_defines.svh"

module rps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  motor_cmd,
  input wire logic        motor_running,
  input wire logic [15:0] ticks_left
);
  import rps_pkg::*;

  logic        req_fire;
  logic        res_hard;
  logic        res_rumble;
  logic [18:0] res_bits;

  assign req_fire   = req_valid && req_ready;
  assign res_hard   = res_valid && motor_cmd == CMD_HARD;
  assign res_rumble = res_valid && motor_cmd == CMD_RUMBLE;
  assign res_bits   = {motor_cmd, motor_running, ticks_left};

  `RPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bits), "result not held")
  `RPS_ASSERT_NOW(a_hard_stop, res_hard, !motor_running && ticks_left == '0, "running after hard stop")
  `RPS_ASSERT_NOW(a_rumble_on, res_rumble, motor_running && ticks_left != '0, "rumble while stopped")
  `RPS_ASSERT_NOW(a_latency, req_fire && !res_valid, ##2 res_valid, "request result late")

endmodule

bind rumble_pulse_sequencer rps_checker u_rps_checker (.*);

`default_nettype wire

// ===== bench/tb_rumble_pulse_sequencer.sv =====
// ----------------------------------------------------------------------------
// Rumble pulse sequencer testbench
// Feeds requests from a queue through a bursty valid/ready driver, stalls the
// result channel on shifting patterns with one long hold-off, and compares
// every result against a cycle-free model of the motor pattern state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rumble_pulse_sequencer;
  import rps_pkg::*;

  localparam int TOTAL_ITEMS    = 1550;
  localparam int HOLDOFF_AT     = 700;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_CYCLIC} rdy_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  req_type = REQ_TICK;
  logic [15:0] on_frames = '0;
  logic [15:0] off_frames = '0;
  logic [7:0]  pulse_count = '0;
  logic        hard_stop = 1'b0;
  logic [15:0] single_frames = '0;
  logic [15:0] damage_amount = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [1:0]  motor_cmd;
  logic        motor_running;
  logic [15:0] ticks_left;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   items_queued = 0;
  int   reqs_sent = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  logic req_fire = 1'b0;

  logic [15:0] pat_countdown = '0;
  logic [15:0] pat_on_len = '0;
  logic [15:0] pat_off_len = '0;
  logic [7:0]  pat_pulses = '0;
  logic        pat_motor_on = 1'b0;
  logic        pat_hard_end = 1'b0;

  rumble_pulse_sequencer u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .on_frames     (on_frames),
    .off_frames    (off_frames),
    .pulse_count   (pulse_count),
    .hard_stop     (hard_stop),
    .single_frames (single_frames),
    .damage_amount (damage_amount),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .motor_cmd     (motor_cmd),
    .motor_running (motor_running),
    .ticks_left    (ticks_left)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [1:0] launch_pattern(input logic [15:0] on_len,
                                                input logic [15:0] off_len,
                                                input logic [7:0] pulses,
                                                input logic hard);
    if (on_len == 16'd0 || pulses == 8'd0) return CMD_NONE;
    pat_on_len    = on_len;
    pat_off_len   = off_len;
    pat_pulses    = pulses;
    pat_countdown = on_len;
    pat_motor_on  = 1'b1;
    pat_hard_end  = hard;
    return CMD_RUMBLE;
  endfunction

  function automatic res_t predict_motor(input req_t r);
    logic [1:0]  cmd;
    logic [15:0] len;
    res_t        res;
    cmd = CMD_NONE;
    len = '0;
    case (r.req_type)
      REQ_TICK: begin
        if (pat_countdown != 16'd0) begin
          pat_countdown = pat_countdown - 16'd1;
          if (pat_countdown == 16'd0) begin
            if (!pat_motor_on) begin
              pat_motor_on  = 1'b1;
              pat_countdown = pat_on_len;
              cmd = CMD_RUMBLE;
            end else if (pat_pulses <= 8'd1) begin
              pat_pulses   = 8'd0;
              pat_motor_on = 1'b0;
              cmd = pat_hard_end ? CMD_HARD : CMD_SOFT;
            end else begin
              pat_pulses = pat_pulses - 8'd1;
              if (pat_off_len != 16'd0) begin
                pat_motor_on  = 1'b0;
                pat_countdown = pat_off_len;
                cmd = CMD_SOFT;
              end else begin
                pat_countdown = pat_on_len;
              end
            end
          end
        end
      end
      REQ_START: begin
        cmd = launch_pattern(r.on_frames, r.off_frames, r.pulse_count, r.hard_stop);
      end
      default: begin
        if (r.req_type == REQ_SINGLE) len = r.single_frames;
        else if (r.damage_amount >= DMG_HEAVY) len = 16'(LEN_HEAVY);
        else if (r.damage_amount >= DMG_HIGH) len = 16'(LEN_HIGH);
        else if (r.damage_amount >= DMG_MID) len = 16'(LEN_MID);
        else if (r.damage_amount >= DMG_LOW) len = 16'(LEN_LOW);
        else if (r.damage_amount != 16'd0) len = 16'(LEN_MIN);
        if (len != 16'd0) begin
          if (len > pat_countdown) pat_countdown = len;
          if (!(pat_motor_on && pat_pulses == 8'd1))
            cmd = launch_pattern(len, 16'd0, 8'd1, 1'b1);
        end
      end
    endcase
    res.motor_cmd     = cmd;
    res.motor_running = pat_motor_on;
    res.ticks_left    = pat_countdown;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic push_req(input req_t r);
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  function automatic req_t random_req();
    req_t r;
    r.req_type      = 2'($urandom_range(0, 3));
    r.on_frames     = 16'($urandom_range(0, 65535));
    r.off_frames    = 16'($urandom_range(0, 65535));
    r.pulse_count   = 8'($urandom_range(0, 255));
    r.hard_stop     = 1'($urandom_range(0, 1));
    r.single_frames = 16'($urandom_range(0, 65535));
    r.damage_amount = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [15:0] on_len,
                         input logic [15:0] off_len, input logic [7:0] pulses,
                         input logic hard, input logic [15:0] single_len,
                         input logic [15:0] dmg);
    req_t r;
    r.req_type      = kind;
    r.on_frames     = on_len;
    r.off_frames    = off_len;
    r.pulse_count   = pulses;
    r.hard_stop     = hard;
    r.single_frames = single_len;
    r.damage_amount = dmg;
    push_req(r);
  endtask

  task automatic queue_pattern_run();
    req_t r;
    int   on_len;
    int   off_len;
    int   pulses;
    int   n_ticks;
    on_len  = $urandom_range(1, 4);
    off_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    pulses  = $urandom_range(1, 5);
    r = random_req();
    r.req_type    = REQ_START;
    r.on_frames   = 16'(on_len);
    r.off_frames  = 16'(off_len);
    r.pulse_count = 8'(pulses);
    push_req(r);
    n_ticks = pulses * (on_len + off_len) + $urandom_range(0, 3);
    if ($urandom_range(0, 4) == 0) n_ticks = $urandom_range(0, n_ticks);
    repeat (n_ticks) begin
      r = random_req();
      case ($urandom_range(0, 11))
        0: begin
          r.req_type = REQ_SINGLE;
          if ($urandom_range(0, 3) != 0) r.single_frames = 16'($urandom_range(0, 10));
        end
        1: begin
          r.req_type = REQ_DAMAGE;
          if ($urandom_range(0, 2) != 0) r.damage_amount = 16'($urandom_range(0, 120));
        end
        default: r.req_type = REQ_TICK;
      endcase
      push_req(r);
    end
  endtask

  // Hold the request until taken; send in bursts separated by gaps.
  always @(negedge clk) begin : drive_requests
    static int gap_left = 0;
    static int burst_left = 1;
    req_t cur;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (gap_left != 0 || pending_reqs.size() == 0) begin
        if (gap_left != 0) gap_left--;
        req_valid <= 1'b0;
      end else begin
        cur = pending_reqs.pop_front();
        req_valid     <= 1'b1;
        req_type      <= cur.req_type;
        on_frames     <= cur.on_frames;
        off_frames    <= cur.off_frames;
        pulse_count   <= cur.pulse_count;
        hard_stop     <= cur.hard_stop;
        single_frames <= cur.single_frames;
        damage_amount <= cur.damage_amount;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(0, 2);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Stall the result side on a changing pattern, with one long hold-off.
  always @(negedge clk) begin : drive_result_ready
    static int        stall_phase = 0;
    static int        hold_left = 0;
    static bit        holdoff_done = 1'b0;
    static rdy_mode_e rdy_mode = RDY_ALWAYS;
    logic             rdy;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      stall_phase++;
      if (stall_phase % 97 == 0) rdy_mode = rdy_mode_e'($urandom_range(0, 3));
      if (!holdoff_done && reqs_sent >= HOLDOFF_AT) begin
        hold_left    = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rdy_mode)
          RDY_ALWAYS: rdy = 1'b1;
          RDY_HALF:   rdy = 1'($urandom_range(0, 1));
          RDY_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:    rdy = (stall_phase % 3 != 0);
        endcase
      end
      res_ready <= rdy;
    end
  end

  always @(posedge clk) begin : watch_ports
    res_t want;
    req_t taken;
    if (rst) begin
      req_fire      <= 1'b0;
      pat_countdown = '0;
      pat_on_len    = '0;
      pat_off_len   = '0;
      pat_pulses    = '0;
      pat_motor_on  = 1'b0;
      pat_hard_end  = 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (motor_cmd !== want.motor_cmd)
            flag_mismatch($sformatf("motor_cmd exp %0d got %0d", want.motor_cmd, motor_cmd));
          if (motor_running !== want.motor_running)
            flag_mismatch($sformatf("motor_running exp %0d got %0d",
                                    want.motor_running, motor_running));
          if (ticks_left !== want.ticks_left)
            flag_mismatch($sformatf("ticks_left exp %0d got %0d", want.ticks_left, ticks_left));
        end
      end
      if (req_valid && req_ready) begin
        taken.req_type      = req_type;
        taken.on_frames     = on_frames;
        taken.off_frames    = off_frames;
        taken.pulse_count   = pulse_count;
        taken.hard_stop     = hard_stop;
        taken.single_frames = single_frames;
        taken.damage_amount = damage_amount;
        expected_results.push_back(predict_motor(taken));
        reqs_sent <= reqs_sent + 1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    add_req(REQ_TICK, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_START, 16'd0, 16'd5, 8'd3, 1'b1, 16'd0, 16'd0);
    add_req(REQ_START, 16'd7, 16'd5, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_START, 16'd1, 16'd1, 8'd2, 1'b0, 16'd0, 16'd0);
    repeat (3) add_req(REQ_TICK, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_START, 16'd2, 16'd0, 8'd2, 1'b1, 16'd0, 16'd0);
    repeat (2) add_req(REQ_TICK, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_SINGLE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd3, 16'd0);
    repeat (3) add_req(REQ_TICK, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_SINGLE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd0);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd1);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd100);
    add_req(REQ_START, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd50);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd25);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd10);
    add_req(REQ_DAMAGE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 16'd9);
    add_req(REQ_SINGLE, 16'd0, 16'd0, 8'd0, 1'b0, 16'hFFFF, 16'hFFFF);
    add_req(REQ_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    while (items_queued < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) != 0) queue_pattern_run();
      else push_req(random_req());
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
